// File: src/int8_vector_distance_unit_core_macros.svh
// Assertion macros for the int8 vector distance unit.
`ifndef INT8_VECTOR_DISTANCE_UNIT_CORE_MACROS_SVH
`define INT8_VECTOR_DISTANCE_UNIT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define IVDU_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IVDU_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IVDU_ASSERT_RST(lbl, clk, rst, prop, msg)
`define IVDU_ASSERT(lbl, clk, prop, msg)
`endif
`endif

// File: src/ivdu_pkg.sv
// Shared types and constants of the int8 vector distance unit.
`timescale 1ns / 1ps
`default_nettype none
package ivdu_pkg;
  localparam int MAX_DIM = 4096;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int DSQ_W   = 29;
  localparam int DOT_W   = 28;
  localparam int SQ_W    = 27;
  localparam int PROD_W  = 2 * SQ_W;
  localparam int MAG_W   = DOT_W;
  localparam int D2_W    = 2 * MAG_W;
  localparam int ROOT_W  = 31;
  localparam int WIDE_W  = 116;
  localparam int FRAC_W  = 60;

  localparam logic [1:0] MODE_L2 = 2'd0;
  localparam logic [1:0] MODE_IP = 2'd1;

  typedef struct packed {
    logic [1:0]              mode;
    logic [DSQ_W-1:0]        dsq;
    logic signed [DOT_W-1:0] dot;
    logic [SQ_W-1:0]         asq;
    logic [SQ_W-1:0]         bsq;
    logic                    ovf;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_ROOT, ST_DONE} back_state_t;
endpackage
`default_nettype wire

// File: src/ivdu_ifs.sv
// Item channel interfaces: element pairs in, metric results out.
`timescale 1ns / 1ps
`default_nettype none
interface ivdu_pair_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] a_elem;
  logic signed [7:0] b_elem;
  logic              last;
  modport source(output valid, a_elem, b_elem, last, input ready);
  modport sink(input valid, a_elem, b_elem, last, output ready);
endinterface

interface ivdu_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               zero_norm;
  logic               too_long;
  modport source(output valid, value, zero_norm, too_long, input ready);
  modport sink(input valid, value, zero_norm, too_long, output ready);
endinterface
`default_nettype wire

// File: src/ivdu_front.sv
// Front end: accepts element pairs, accumulates the four sums, emits a job on last.
`timescale 1ns / 1ps
`default_nettype none
module ivdu_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [1:0]    mode,
  ivdu_pair_if.sink          pair,
  output ivdu_pkg::q_wr_t    q_wr,
  input  wire logic          q_full,
  output ivdu_pkg::job_t     job
);
  import ivdu_pkg::*;

  logic [DSQ_W-1:0]        dsq, dsq_next;
  logic signed [DOT_W-1:0] dot, dot_next;
  logic [SQ_W-1:0]         asq, asq_next;
  logic [SQ_W-1:0]         bsq, bsq_next;
  logic [CNT_W-1:0]        cnt, cnt_next;
  logic                    ovf, ovf_next;
  logic                    accept, take;
  logic signed [8:0]       diff;
  logic signed [17:0]      diff_sq;
  logic signed [15:0]      ab, aa, bb;

  assign pair.ready = !q_full;
  assign accept = pair.valid && pair.ready;
  assign take   = cnt < CNT_W'(MAX_DIM);

  always_comb begin
    diff    = 9'(pair.a_elem) - 9'(pair.b_elem);
    diff_sq = diff * diff;
    ab      = pair.a_elem * pair.b_elem;
    aa      = pair.a_elem * pair.a_elem;
    bb      = pair.b_elem * pair.b_elem;
    dsq_next = dsq;
    dot_next = dot;
    asq_next = asq;
    bsq_next = bsq;
    cnt_next = cnt;
    ovf_next = ovf;
    if (take) begin
      dsq_next = dsq + DSQ_W'(diff_sq[15:0]);
      dot_next = dot + DOT_W'(ab);
      asq_next = asq + SQ_W'(aa[14:0]);
      bsq_next = bsq + SQ_W'(bb[14:0]);
      cnt_next = cnt + 1'b1;
    end else begin
      ovf_next = 1'b1;
    end
  end

  assign q_wr.push = accept && pair.last;
  assign q_wr.full = q_full;
  assign job = '{mode: mode, dsq: dsq_next, dot: dot_next, asq: asq_next,
                 bsq: bsq_next, ovf: ovf_next};

  always_ff @(posedge clk) begin
    if (rst || (accept && pair.last)) begin
      dsq <= '0;
      dot <= '0;
      asq <= '0;
      bsq <= '0;
      cnt <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      dsq <= dsq_next;
      dot <= dot_next;
      asq <= asq_next;
      bsq <= bsq_next;
      cnt <= cnt_next;
      ovf <= ovf_next;
    end
  end
endmodule
`default_nettype wire

// File: src/ivdu_queue.sv
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module ivdu_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  ivdu_pkg::q_wr_t wr,
  input  ivdu_pkg::job_t  wr_job,
  output logic            full,
  output logic            empty,
  input  wire logic       pop,
  output ivdu_pkg::job_t  rd_job
);
  import ivdu_pkg::*;

  job_t       mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign do_push = wr.push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop) rp <= !rp;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

// File: src/ivdu_back.sv
// Back end: selects the metric and runs the bit-serial cosine root search.
`timescale 1ns / 1ps
`default_nettype none
module ivdu_back (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_empty,
  output logic           q_pop,
  input  ivdu_pkg::job_t job_in,
  ivdu_result_if.source  result
);
  import ivdu_pkg::*;

  back_state_t        state, state_next;
  job_t               job;
  logic [PROD_W-1:0]  prod;
  logic [D2_W-1:0]    d2;
  logic [ROOT_W-1:0]  m, bitm;
  logic [WIDE_W-1:0]  m2p, x, pk, trial, rhs;
  logic               fits, cos_sel, zero_sel, load_out;
  logic [MAG_W-1:0]   mag;
  logic [ROOT_W-1:0]  m_final;
  logic signed [31:0] val, val_next;
  logic               zn, zn_next;

  assign cos_sel  = job_in.mode[1];
  assign zero_sel = (job_in.asq == '0) || (job_in.bsq == '0);
  assign mag      = job.dot[DOT_W-1] ? MAG_W'(-job.dot) : MAG_W'(job.dot);
  assign prod     = job.asq * job.bsq;

  // Trial square t^2*P is built from the running m^2*P plus the cross term and the new bit.
  assign trial   = m2p + x + pk;
  assign rhs     = {D2_W'(d2), FRAC_W'(0)};
  assign fits    = trial <= rhs;
  assign m_final = fits ? (m | bitm) : m;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!q_empty) state_next = (cos_sel && !zero_sel) ? ST_PREP : ST_DONE;
      ST_PREP: state_next = ST_ROOT;
      ST_ROOT: if (bitm[0]) state_next = ST_DONE;
      ST_DONE: if (!result.valid || result.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == ST_IDLE) && !q_empty;
    load_out = (state == ST_DONE) && (!result.valid || result.ready);
    val_next = val;
    zn_next  = zn;
    if (q_pop) begin
      zn_next = cos_sel && zero_sel;
      priority if (job_in.mode == MODE_L2) val_next = 32'(job_in.dsq);
      else if (job_in.mode == MODE_IP) val_next = 32'(job_in.dot);
      else val_next = '0;
    end else if ((state == ST_ROOT) && bitm[0]) begin
      val_next = job.dot[DOT_W-1] ? -32'(m_final) : 32'(m_final);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job <= job_in;
    val <= val_next;
    zn  <= zn_next;
    unique case (state)
      ST_PREP: begin
        d2   <= mag * mag;
        m    <= '0;
        bitm <= ROOT_W'(1) << (ROOT_W - 1);
        m2p  <= '0;
        x    <= '0;
      end
      ST_ROOT: begin
        m    <= m_final;
        bitm <= bitm >> 1;
        if (fits) begin
          m2p <= trial;
          x   <= (x + (pk << 1)) >> 1;
        end else begin
          x <= x >> 1;
        end
      end
      default: ;
    endcase
    if (state == ST_PREP) pk <= WIDE_W'({prod, FRAC_W'(0)});
    else if (state == ST_ROOT) pk <= pk >> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.value     <= val;
      result.zero_norm <= zn;
      result.too_long  <= job.ovf;
    end
  end
endmodule
`default_nettype wire

// File: src/int8_vector_distance_unit_core.sv
// L2 and inner product results pass from the last accepted pair through the job queue,
// the back end's value register and the output register; cosine adds a setup state and
// a search over 31 root bits, one per cycle. Throughput: one element pair per cycle while
// the queue is not full; the back end takes the next vector only once its result is handed off.
// Two finished vectors can queue ahead of the back end before the input stalls.
// Reset (synchronous, active high) clears all sums, the queue, the output and metric_mode.
`timescale 1ns / 1ps
`default_nettype none
`include "int8_vector_distance_unit_core_macros.svh"
module int8_vector_distance_unit_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       mode_we,
  input  wire logic [1:0] mode_wdata,
  ivdu_pair_if.sink       pair,
  ivdu_result_if.source   result
);
  import ivdu_pkg::*;

  logic [1:0] metric_mode;
  q_wr_t      q_wr;
  job_t       wr_job, rd_job;
  logic       q_full, q_empty, q_pop;
  logic       zn_bad;

  always_ff @(posedge clk) begin
    if (rst) metric_mode <= MODE_L2;
    else if (mode_we) metric_mode <= mode_wdata;
  end

  ivdu_front u_front (
    .clk(clk), .rst(rst), .mode(metric_mode), .pair(pair),
    .q_wr(q_wr), .q_full(q_full), .job(wr_job)
  );

  ivdu_queue u_queue (
    .clk(clk), .rst(rst), .wr(q_wr), .wr_job(wr_job), .full(q_full),
    .empty(q_empty), .pop(q_pop), .rd_job(rd_job)
  );

  ivdu_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_pop(q_pop),
    .job_in(rd_job), .result(result)
  );

  assign zn_bad = result.zero_norm && (result.value != 32'sd0);

  `IVDU_ASSERT_RST(a_no_push_full, clk, rst, q_wr.push |-> !q_full, "job pushed into full queue")
  `IVDU_ASSERT_RST(a_push_lands, clk, rst, q_wr.push |=> !q_empty, "pushed job not queued")
  `IVDU_ASSERT_RST(a_zero_norm_val, clk, rst, result.valid |-> !zn_bad, "zero norm, nonzero value")
endmodule
`default_nettype wire
